### sv/vlsm_pkg.sv
// vlsm_pkg: constants and types for the vertical line scale mapper
// no dependencies; imported by vertical_line_scale_mapper_top and its testbench
`default_nettype none

package vlsm_pkg;

  localparam int DST_LINES      = 135;
  localparam int SRC_LINES      = 256;
  localparam int MAX_RESULTS    = 64;
  localparam int DEFAULT_HEIGHT = 224;
  localparam int MIN_HEIGHT     = 8;

  localparam int HEIGHT_W = 9;   // source_height register
  localparam int LINE_W   = 8;   // display / source line numbers
  localparam int CNT_W    = $clog2(MAX_RESULTS);
  localparam int NUM_W    = 17;  // (2*d+1)*h
  localparam int HALF_W   = NUM_W - 1;

  // floor(x / DST_LINES) as (x * RECIP) >> RECIP_SHIFT, exact for x < 2**HALF_W
  localparam int RECIP_SHIFT = HALF_W + 8;
  localparam int RECIP_W     = 17;
  localparam int RECIP       = (2 ** RECIP_SHIFT + DST_LINES - 1) / DST_LINES;
  localparam int PROD_W      = HALF_W + RECIP_W;

  typedef enum logic [1:0] {
    REG_SOURCE_HEIGHT = 2'd0,
    REG_INTERLACE_ON  = 2'd1,
    REG_FIELD_SELECT  = 2'd2,
    REG_HALF_SKIP_ON  = 2'd3
  } reg_index_t;

  typedef enum logic {
    FUNC_REBUILD = 1'b0,
    FUNC_LINE    = 1'b1
  } func_t;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_WALK  = 5'b00010,
    S_DRAIN = 5'b00100,
    S_LOOK  = 5'b01000,
    S_EMIT  = 5'b10000
  } state_t;

endpackage

`default_nettype wire

### sv/vertical_line_scale_mapper_top.sv
// vertical line scale mapper: nearest-neighbor map from display lines to source lines
// depends on vlsm_pkg; {first, last} display line per source line in one map memory
// rebuild request: walks display lines from parity by map_step, one line per cycle
// line request: map read registered on accept, then S_LOOK and S_EMIT; up to 64 results,
//   one per cycle unless stalled; next request is taken while the last result is held
// synchronous reset clears control and all source valid bits
`default_nettype none

module vertical_line_scale_mapper_top (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        s_tvalid,
  output logic                             s_tready,
  input  wire logic [7:0]                  s_tdata,   // [7:0] src_line
  input  wire logic [0:0]                  s_tuser,   // [0] func
  output logic                             m_tvalid,
  input  wire logic                        m_tready,
  output logic [7:0]                       m_tdata,   // [7:0] dst_line
  output logic [0:0]                       m_tuser,   // [0] present
  output logic                             m_tlast,
  input  wire logic                        cfg_we,
  input  wire logic [1:0]                  cfg_index,
  input  wire logic [vlsm_pkg::HEIGHT_W-1:0] cfg_data
);
  import vlsm_pkg::*;

  // configuration
  logic [HEIGHT_W-1:0] source_height;
  logic                interlace_on;
  logic                field_select;
  logic                half_skip_on;

  // control
  state_t              state;
  logic [1:0]          map_step;
  logic [HEIGHT_W-1:0] h_act;
  logic                parity;
  logic                snap_on;
  logic [SRC_LINES-1:0] src_valid;

  // walk
  logic [LINE_W-1:0]   d_walk;
  logic [NUM_W-1:0]    num_walk;
  logic [NUM_W-1:0]    num_inc;
  logic                st1_valid;
  logic [LINE_W-1:0]   st1_d;
  logic [PROD_W-1:0]   st1_prod;
  logic                run_any;
  logic [LINE_W-1:0]   run_src;
  logic [LINE_W-1:0]   run_first;

  // lookup / emit
  logic                hit;
  logic                miss;
  logic [LINE_W-1:0]   cur_d;
  logic [LINE_W-1:0]   last_d;
  logic [CNT_W-1:0]    count;

  // map memory
  logic [2*LINE_W-1:0] map_mem [SRC_LINES];
  logic [2*LINE_W-1:0] rd_data;

  logic                accept;
  logic                out_free;
  logic                emit;
  logic                fin;
  logic [HEIGHT_W-1:0] h_cfg;
  logic                par_cfg;
  logic [LINE_W:0]     d_adv;
  logic [HEIGHT_W-1:0] s_raw;
  logic [HEIGHT_W-1:0] s_clip;
  logic [HEIGHT_W-1:0] s_snap;
  logic [LINE_W-1:0]   wr_addr;
  logic [LINE_W-1:0]   wr_first;

  assign accept   = s_tvalid && s_tready;
  assign s_tready = (state == S_IDLE);
  assign out_free = !m_tvalid || m_tready;
  assign emit     = (state == S_EMIT) && out_free;
  assign fin      = miss || (cur_d == last_d) ||
                    (count == CNT_W'(MAX_RESULTS - 1));

  // active height: 0 means default, then saturate to the legal range
  always_comb begin
    h_cfg = source_height;
    if (h_cfg == '0) h_cfg = HEIGHT_W'(DEFAULT_HEIGHT);
    if (h_cfg < HEIGHT_W'(MIN_HEIGHT)) h_cfg = HEIGHT_W'(MIN_HEIGHT);
    if (h_cfg > HEIGHT_W'(SRC_LINES)) h_cfg = HEIGHT_W'(SRC_LINES);
  end

  assign par_cfg = interlace_on & field_select;
  assign d_adv   = {1'b0, d_walk} + {{(LINE_W-1){1'b0}}, map_step};
  assign num_inc = (map_step == 2'd2) ? {{(NUM_W-HEIGHT_W-2){1'b0}}, h_act, 2'b00}
                                      : {{(NUM_W-HEIGHT_W-1){1'b0}}, h_act, 1'b0};

  // stage 2: clamp and snap the source line, then record the run
  always_comb begin
    s_raw  = st1_prod[PROD_W-1:RECIP_SHIFT];
    s_clip = (s_raw >= h_act) ? (h_act - 1'b1) : s_raw;
    s_snap = s_clip;
    if (snap_on && (s_clip[0] != parity)) begin
      if ((s_clip + 1'b1) < h_act) s_snap = s_clip + 1'b1;
      else if (s_clip != '0)       s_snap = s_clip - 1'b1;
    end
    wr_addr  = s_snap[LINE_W-1:0];
    wr_first = (run_any && (run_src == wr_addr)) ? run_first : st1_d;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      source_height <= HEIGHT_W'(DEFAULT_HEIGHT);
      interlace_on  <= 1'b0;
      field_select  <= 1'b0;
      half_skip_on  <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SOURCE_HEIGHT: source_height <= cfg_data;
        REG_INTERLACE_ON:  interlace_on  <= cfg_data[0];
        REG_FIELD_SELECT:  field_select  <= cfg_data[0];
        REG_HALF_SKIP_ON:  half_skip_on  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // map memory: written by the walk, read by line requests
  always_ff @(posedge clk) begin
    if (st1_valid) begin
      map_mem[wr_addr] <= {wr_first, st1_d};
    end
    if (accept) begin
      rd_data <= map_mem[s_tdata];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      map_step  <= 2'd1;
      src_valid <= '0;
      st1_valid <= 1'b0;
      run_any   <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      if (m_tready && !emit) m_tvalid <= 1'b0;

      if (st1_valid) begin
        src_valid[wr_addr] <= 1'b1;
        run_any            <= 1'b1;
        run_src            <= wr_addr;
        run_first          <= wr_first;
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            if (s_tuser[0] == FUNC_REBUILD) begin
              src_valid <= '0;
              run_any   <= 1'b0;
              map_step  <= interlace_on ? 2'd2 : 2'd1;
              h_act     <= h_cfg;
              parity    <= par_cfg;
              snap_on   <= half_skip_on;
              d_walk    <= {{(LINE_W-1){1'b0}}, par_cfg};
              num_walk  <= {{(NUM_W-HEIGHT_W){1'b0}}, h_cfg} +
                           (par_cfg ? {{(NUM_W-HEIGHT_W-1){1'b0}}, h_cfg, 1'b0} : '0);
              state     <= S_WALK;
            end else begin
              hit   <= src_valid[s_tdata];
              state <= S_LOOK;
            end
          end
        end
        S_WALK: begin
          st1_valid <= 1'b1;
          st1_d     <= d_walk;
          st1_prod  <= PROD_W'(num_walk[NUM_W-1:1] * RECIP_W'(RECIP));
          d_walk    <= d_adv[LINE_W-1:0];
          num_walk  <= num_walk + num_inc;
          if (d_adv >= (LINE_W+1)'(DST_LINES)) state <= S_DRAIN;
        end
        S_DRAIN: begin
          st1_valid <= 1'b0;
          state     <= S_IDLE;
        end
        S_LOOK: begin
          miss   <= !hit;
          cur_d  <= rd_data[2*LINE_W-1:LINE_W];
          last_d <= rd_data[LINE_W-1:0];
          count  <= '0;
          state  <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            m_tvalid   <= 1'b1;
            m_tdata    <= miss ? '0 : cur_d;
            m_tuser[0] <= !miss;
            m_tlast    <= fin;
            cur_d      <= cur_d + {{(LINE_W-2){1'b0}}, map_step};
            count      <= count + 1'b1;
            if (fin) state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_walk_only: assert property (@(posedge clk) disable iff (rst)
    st1_valid |-> (state == S_WALK || state == S_DRAIN))
    else $error("walk pipeline active outside rebuild");

  a_miss_is_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser[0]) |-> m_tlast)
    else $error("unneeded-line result not marked last");

  a_run_order: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && !miss) |-> (cur_d <= last_d))
    else $error("display line walked past end of run");

  a_rebuild_clears: assert property (@(posedge clk) disable iff (rst)
    (accept && s_tuser[0] == FUNC_REBUILD) |=> (src_valid == '0))
    else $error("rebuild did not clear source valid bits");

endmodule

`default_nettype wire

### tb/tb_vertical_line_scale_mapper_top.sv
// testbench for vertical_line_scale_mapper_top: line and rebuild requests with random gaps,
// results checked against an in-bench model of the display-to-source line map
// depends on vlsm_pkg and vertical_line_scale_mapper_top
`timescale 1ns / 1ps

module tb_vertical_line_scale_mapper_top;
  import vlsm_pkg::*;

  // a rebuild keeps walking display lines after its request is taken
  localparam int WALK_CYCLES = DST_LINES + 16;
  localparam int DRAIN_CYCLES = 20;

  typedef struct packed {
    logic [7:0] dst_line;
    logic       present;
    logic       last_of_run;
  } line_result_t;

  logic                clk;
  logic                rst;
  logic                s_tvalid;
  logic                s_tready;
  logic [7:0]          s_tdata;
  logic [0:0]          s_tuser;
  logic                m_tvalid;
  logic                m_tready;
  logic [7:0]          m_tdata;
  logic [0:0]          m_tuser;
  logic                m_tlast;
  logic                cfg_we;
  logic [1:0]          cfg_index;
  logic [HEIGHT_W-1:0] cfg_data;

  vertical_line_scale_mapper_top dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // register copies, as written
  logic [8:0] cfg_height = 9'(DEFAULT_HEIGHT);
  logic       cfg_interlace = 1'b0;
  logic       cfg_field = 1'b0;
  logic       cfg_half_skip = 1'b1;

  // line map as of the last rebuild
  logic [8:0]  map_src     [DST_LINES];
  bit          map_disp_ok [DST_LINES];
  logic [7:0]  map_first   [SRC_LINES];
  logic [7:0]  map_last    [SRC_LINES];
  bit          map_src_ok  [SRC_LINES];
  int unsigned map_stride = 1;
  int unsigned map_height = DEFAULT_HEIGHT;

  line_result_t pending_results[$];

  int  mismatches = 0;
  int  results_seen = 0;
  int  line_requests = 0;
  int  rebuild_requests = 0;
  int  settings_used = 0;
  bit  no_gaps = 1'b0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic map_rebuild();
    int unsigned h;
    int unsigned par;
    int unsigned s;
    h = cfg_height;
    if (h == 0) h = DEFAULT_HEIGHT;
    if (h < MIN_HEIGHT) h = MIN_HEIGHT;
    if (h > SRC_LINES) h = SRC_LINES;
    par = cfg_interlace ? cfg_field : 0;
    map_height = h;
    map_stride = cfg_interlace ? 2 : 1;
    foreach (map_disp_ok[i]) map_disp_ok[i] = 1'b0;
    foreach (map_src_ok[i]) map_src_ok[i] = 1'b0;
    for (int d = par; d < DST_LINES; d += map_stride) begin
      s = ((2 * d + 1) * h) / (2 * DST_LINES);
      if (s >= h) s = h - 1;
      // snap to field parity: next line if it exists, else previous
      if (cfg_half_skip && (s % 2) != par) begin
        if (s + 1 < h) s = s + 1;
        else if (s > 0) s = s - 1;
      end
      map_src[d] = 9'(s);
      map_disp_ok[d] = 1'b1;
      if (!map_src_ok[s]) begin
        map_src_ok[s] = 1'b1;
        map_first[s] = 8'(d);
      end
      map_last[s] = 8'(d);
    end
  endtask

  task automatic map_lookup(logic [7:0] line);
    line_result_t found[$];
    line_result_t r;
    if (map_src_ok[line]) begin
      for (int d = map_first[line]; d <= map_last[line] && d < DST_LINES; d += map_stride)
        if (map_disp_ok[d] && map_src[d] == {1'b0, line} && found.size() < MAX_RESULTS) begin
          r.dst_line = 8'(d);
          r.present = 1'b1;
          r.last_of_run = 1'b0;
          found.push_back(r);
        end
    end
    if (found.size() == 0) begin
      // source line not needed
      r.dst_line = 8'd0;
      r.present = 1'b0;
      r.last_of_run = 1'b1;
      found.push_back(r);
    end
    found[found.size() - 1].last_of_run = 1'b1;
    foreach (found[i]) pending_results.push_back(found[i]);
  endtask

  task automatic send_request(func_t f, logic [7:0] line);
    if (!no_gaps && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= f;
    s_tdata <= line;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (f == FUNC_REBUILD) begin
      rebuild_requests++;
      map_rebuild();
    end else begin
      line_requests++;
      map_lookup(line);
    end
  endtask

  // block must be idle: all results back and any rebuild walk finished
  task automatic settle();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (WALK_CYCLES) @(posedge clk);
  endtask

  task automatic write_config(logic [8:0] h, logic il, logic fs, logic hs);
    settle();
    cfg_we <= 1'b1;
    cfg_index <= REG_SOURCE_HEIGHT;
    cfg_data <= h;
    @(posedge clk);
    cfg_index <= REG_INTERLACE_ON;
    cfg_data <= {8'd0, il};
    @(posedge clk);
    cfg_index <= REG_FIELD_SELECT;
    cfg_data <= {8'd0, fs};
    @(posedge clk);
    cfg_index <= REG_HALF_SKIP_ON;
    cfg_data <= {8'd0, hs};
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg_height = h;
    cfg_interlace = il;
    cfg_field = fs;
    cfg_half_skip = hs;
    settings_used++;
  endtask

  task automatic test_lines_before_rebuild();
    send_request(FUNC_LINE, 8'd0);
    send_request(FUNC_LINE, 8'd255);
  endtask

  task automatic test_reset_map();
    send_request(FUNC_REBUILD, 8'd0);
    send_request(FUNC_LINE, 8'd0);
    send_request(FUNC_LINE, 8'd1);
    send_request(FUNC_LINE, 8'd223);
    send_request(FUNC_LINE, 8'd255);
  endtask

  // new registers only count from the next rebuild
  task automatic test_deferred_config();
    write_config(9'd8, 1'b1, 1'b1, 1'b0);
    send_request(FUNC_LINE, 8'd0);
    send_request(FUNC_REBUILD, 8'hff);
    send_request(FUNC_LINE, 8'd0);
    send_request(FUNC_LINE, 8'd1);
    send_request(FUNC_LINE, 8'd7);
  endtask

  task automatic test_height_extremes();
    write_config(9'd0, 1'b0, 1'b0, 1'b0);
    send_request(FUNC_REBUILD, 8'd0);
    send_request(FUNC_LINE, 8'd223);
    write_config(9'd1, 1'b0, 1'b1, 1'b1);
    send_request(FUNC_REBUILD, 8'd0);
    send_request(FUNC_LINE, 8'd7);
    write_config(9'd511, 1'b1, 1'b0, 1'b1);
    send_request(FUNC_REBUILD, 8'd0);
    send_request(FUNC_LINE, 8'd254);
    send_request(FUNC_LINE, 8'd255);
  endtask

  task automatic test_random_frames();
    int sent;
    int frame_len;
    int rebuild_at;
    logic [8:0] h;
    sent = 0;
    while (sent < 350) begin
      case ($urandom_range(0, 5))
        0:       h = 9'd0;
        1:       h = 9'($urandom_range(1, 7));
        2:       h = 9'd8;
        3:       h = 9'd256;
        4:       h = 9'($urandom_range(257, 511));
        default: h = 9'($urandom_range(9, 255));
      endcase
      write_config(h, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)));
      no_gaps = (sent >= 290) || ($urandom_range(0, 4) == 0);
      frame_len = $urandom_range(15, 35);
      // mostly rebuild first; sometimes run lines on the old map a while
      rebuild_at = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 10) : 0;
      for (int i = 0; i < frame_len; i++) begin
        if (i == rebuild_at || $urandom_range(0, 19) == 0)
          send_request(FUNC_REBUILD, 8'($urandom_range(0, 255)));
        else if ($urandom_range(0, 6) == 0)
          send_request(FUNC_LINE, 8'($urandom_range(0, 255)));
        else
          send_request(FUNC_LINE, 8'($urandom_range(0, map_height - 1)));
        sent++;
      end
    end
  endtask

  // result side: random stall bursts unless gaps are off
  initial begin
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!no_gaps && $urandom_range(0, 9) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    line_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("unexpected result: dst_line %0d present %0d last_of_run %0d",
               m_tdata, m_tuser[0], m_tlast);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (m_tdata !== want.dst_line) begin
          $error("dst_line: expected %0d, got %0d", want.dst_line, m_tdata);
          mismatches++;
        end
        if (m_tuser[0] !== want.present) begin
          $error("present: expected %0d, got %0d", want.present, m_tuser[0]);
          mismatches++;
        end
        if (m_tlast !== want.last_of_run) begin
          $error("last_of_run: expected %0d, got %0d", want.last_of_run, m_tlast);
          mismatches++;
        end
      end
    end
  end

  initial begin
    #10_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    rst <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata <= 8'd0;
    s_tuser <= FUNC_REBUILD;
    cfg_we <= 1'b0;
    cfg_index <= REG_SOURCE_HEIGHT;
    cfg_data <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_lines_before_rebuild();
    test_reset_map();
    test_deferred_config();
    test_height_extremes();
    test_random_frames();

    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("summary: %0d line and %0d rebuild requests, %0d results compared",
             line_requests, rebuild_requests, results_seen);
    $display("summary: %0d register settings incl. default, saturated and maximum heights",
             settings_used);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### vertical_line_scale_mapper_top.f
sv/vlsm_pkg.sv
sv/vertical_line_scale_mapper_top.sv
tb/tb_vertical_line_scale_mapper_top.sv
